// ===== design/dpbp_pkg.sv =====
// shared types and constants for the depth pixel back-projection block
`default_nettype none
package dpbp_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_INV_DEPTH_SCALE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_X     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_Y     = 3'd4;

  // register reset values
  localparam logic [23:0] RST_INV_DEPTH_SCALE = 24'd16777;
  localparam logic [15:0] RST_CENTER_X        = 16'd5208;
  localparam logic [15:0] RST_CENTER_Y        = 16'd4056;
  localparam logic [23:0] RST_INV_FOCAL_X     = 24'd32389;
  localparam logic [23:0] RST_INV_FOCAL_Y     = 24'd32389;

  localparam logic [23:0] POS_MAX24 = 24'h7FFFFF;
  localparam logic [23:0] NEG_MAX24 = 24'h800000;
  localparam logic [23:0] MAX24U    = 24'hFFFFFF;

  // load enables of the five pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

endpackage
`default_nettype wire

// ===== design/dpbp_axis.sv =====
// one lateral axis: pixel offset, scale by depth and reciprocal focal length, saturate
`default_nettype none
module dpbp_axis (
  input  wire                     clk,
  input  dpbp_pkg::stage_en_t     en,
  input  wire  [11:0]             pixel,
  input  wire  [15:0]             center,
  input  wire  [31:0]             zq,
  input  wire  [23:0]             inv_f,
  output logic [23:0]             point
);
  import dpbp_pkg::*;

  logic [15:0] pix4;
  logic [15:0] mag1, mag2;
  logic        neg1, neg2, neg3, neg4;
  logic [47:0] m3;
  logic [47:0] hi4, lo4;
  logic [48:0] lo_round;
  logic [48:0] total;
  logic [44:0] mag;
  logic [23:0] point_next;

  assign pix4 = {pixel, 4'b0000};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      neg1 <= pix4 < center;
      mag1 <= (pix4 < center) ? (center - pix4) : (pix4 - center);
    end
    if (en.s2) begin
      neg2 <= neg1;
      mag2 <= mag1;
    end
    if (en.s3) begin
      neg3 <= neg2;
      m3   <= {32'd0, mag2} * {16'd0, zq};
    end
    if (en.s4) begin
      neg4 <= neg3;
      hi4  <= {24'd0, m3[47:24]} * {24'd0, inv_f};
      lo4  <= {24'd0, m3[23:0]} * {24'd0, inv_f};
    end
    if (en.s5) begin
      point <= point_next;
    end
  end

  // split product keeps each multiplier at 24x24; rounding half up at bit 27
  always_comb begin
    lo_round = {1'b0, lo4} + 49'(28'h8000000);
    total    = {1'b0, hi4} + {24'd0, lo_round[48:24]};
    mag      = total[48:4];
    if (neg4) begin
      if (mag > {21'd0, NEG_MAX24}) begin
        point_next = NEG_MAX24;
      end else begin
        point_next = 24'd0 - mag[23:0];
      end
    end else begin
      if (mag > {21'd0, POS_MAX24}) begin
        point_next = POS_MAX24;
      end else begin
        point_next = mag[23:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/depth_pixel_back_projection_unit.sv =====
// Depth pixel back-projection: lifts a depth pixel to a 3-D point in Q8.16
// meters with its color. Five register stages (depth multiply, depth
// rounding, offset times depth, times reciprocal focal length, round and
// saturate) carry each item, and a new item is taken every cycle while
// in_stall is low. Pixels with zero depth or outside the frame are dropped
// at entry and give no item. in_stall rises only when every stage holds an
// item and the output is stalled; bubbles in the pipeline are squeezed out.
// Configuration is written through cfg_write/cfg_index/cfg_data while the
// block is idle; unknown indexes are ignored.
`default_nettype none
module depth_pixel_back_projection_unit #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_write,
  input  wire  [dpbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [dpbp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [11:0]                       column_index,
  input  wire  [11:0]                       row_index,
  input  wire  [15:0]                       depth_value,
  input  wire  [7:0]                        blue_value,
  input  wire  [7:0]                        green_value,
  input  wire  [7:0]                        red_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [23:0]                       point_x,
  output logic [23:0]                       point_y,
  output logic [23:0]                       point_z,
  output logic [7:0]                        color_blue,
  output logic [7:0]                        color_green,
  output logic [7:0]                        color_red
);
  import dpbp_pkg::*;

  localparam logic [16:0] COL_LIMIT = 17'(MAX_COLUMNS);
  localparam logic [16:0] ROW_LIMIT = 17'(MAX_ROWS);

  logic [23:0] inv_depth_scale;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [23:0] inv_focal_x;
  logic [23:0] inv_focal_y;

  stage_en_t   en;
  logic        v1, v2, v3, v4;
  logic        keep;
  logic [39:0] prod1;
  logic [40:0] zsum;
  logic [31:0] zq2;
  logic [23:0] z3, z4;
  color_t      color_in, c1, c2, c3, c4, c5;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_depth_scale <= RST_INV_DEPTH_SCALE;
      center_x        <= RST_CENTER_X;
      center_y        <= RST_CENTER_Y;
      inv_focal_x     <= RST_INV_FOCAL_X;
      inv_focal_y     <= RST_INV_FOCAL_Y;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INV_DEPTH_SCALE: inv_depth_scale <= cfg_data;
        REG_CENTER_X:        center_x        <= cfg_data[15:0];
        REG_CENTER_Y:        center_y        <= cfg_data[15:0];
        REG_INV_FOCAL_X:     inv_focal_x     <= cfg_data;
        REG_INV_FOCAL_Y:     inv_focal_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its item moves on
  always_comb begin
    en.s5 = !out_valid || !out_stall;
    en.s4 = !v4 || en.s5;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign in_stall = !en.s1;
  assign keep = (depth_value != 16'd0) &&
                ({5'd0, column_index} < COL_LIMIT) &&
                ({5'd0, row_index} < ROW_LIMIT);
  assign color_in = '{blue: blue_value, green: green_value, red: red_value};
  assign zsum = {1'b0, prod1} + 41'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en.s1) v1 <= in_valid && keep;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
      if (en.s5) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod1 <= {24'd0, depth_value} * {16'd0, inv_depth_scale};
      c1    <= color_in;
    end
    if (en.s2) begin
      zq2 <= zsum[39:8];
      c2  <= c1;
    end
    if (en.s3) begin
      z3 <= (|zq2[31:24]) ? MAX24U : zq2[23:0];
      c3 <= c2;
    end
    if (en.s4) begin
      z4 <= z3;
      c4 <= c3;
    end
    if (en.s5) begin
      point_z <= z4;
      c5      <= c4;
    end
  end

  assign color_blue  = c5.blue;
  assign color_green = c5.green;
  assign color_red   = c5.red;

  dpbp_axis u_axis_x (
    .clk    (clk),
    .en     (en),
    .pixel  (column_index),
    .center (center_x),
    .zq     (zq2),
    .inv_f  (inv_focal_x),
    .point  (point_x)
  );

  dpbp_axis u_axis_y (
    .clk    (clk),
    .en     (en),
    .pixel  (row_index),
    .center (center_y),
    .zq     (zq2),
    .inv_f  (inv_focal_y),
    .point  (point_y)
  );

  // input stalls only with every stage occupied and the output held
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  // zero-depth pixels never occupy the first stage
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && depth_value == 16'd0) |=> !v1)
    else $error("zero-depth item entered the pipeline");

  // reset empties the pipeline
  assert property (@(posedge clk)
    rst |=> (!out_valid && !v1 && !v4 && !in_stall))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ===== bench/depth_pixel_back_projection_unit_tb.sv =====
// self-checking testbench for depth_pixel_back_projection_unit: predicts each 3-D point
`timescale 1ns / 100ps

typedef struct packed {
  logic [23:0]       x;
  logic [23:0]       y;
  logic [23:0]       z;
  dpbp_pkg::color_t  color;
} point_t;

class point_tracker;
  logic [23:0] inv_depth_scale;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [23:0] inv_focal_x;
  logic [23:0] inv_focal_y;
  point_t      pending_points[$];
  int          errors;
  int          reports;

  function new();
    inv_depth_scale = dpbp_pkg::RST_INV_DEPTH_SCALE;
    center_x        = dpbp_pkg::RST_CENTER_X;
    center_y        = dpbp_pkg::RST_CENTER_Y;
    inv_focal_x     = dpbp_pkg::RST_INV_FOCAL_X;
    inv_focal_y     = dpbp_pkg::RST_INV_FOCAL_Y;
    errors          = 0;
    reports         = 0;
  endfunction

  function void write_reg(logic [2:0] index, logic [23:0] data);
    case (index)
      dpbp_pkg::REG_INV_DEPTH_SCALE: inv_depth_scale = data;
      dpbp_pkg::REG_CENTER_X:        center_x = data[15:0];
      dpbp_pkg::REG_CENTER_Y:        center_y = data[15:0];
      dpbp_pkg::REG_INV_FOCAL_X:     inv_focal_x = data;
      dpbp_pkg::REG_INV_FOCAL_Y:     inv_focal_y = data;
      default: ;
    endcase
  endfunction

  function void note_failure(string msg);
    errors++;
    if (reports < 10) begin
      reports++;
      $display("%s", msg);
    end
  endfunction

  // (pixel - center) * z * inv_f, rounded half away from zero, saturated to 24 bits
  function logic [23:0] axis_coord(logic [11:0] pixel, logic [15:0] center, logic [63:0] zq,
                                   logic [23:0] inv_f);
    logic [15:0] pix4;
    logic        neg;
    logic [63:0] off;
    logic [63:0] m;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] a;
    logic [63:0] mag;
    pix4 = {pixel, 4'b0000};
    neg  = pix4 < center;
    off  = neg ? {48'd0, center - pix4} : {48'd0, pix4 - center};
    m    = off * zq;
    hi   = m >> 24;
    lo   = m & 64'hFFFFFF;
    a    = lo * {40'd0, inv_f} + (64'd1 << 27);
    mag  = (hi * {40'd0, inv_f} + (a >> 24)) >> 4;
    if (neg) begin
      if (mag > 64'h800000) mag = 64'h800000;
      mag = 64'h1000000 - mag;
      return mag[23:0];
    end
    if (mag > 64'h7FFFFF) mag = 64'h7FFFFF;
    return mag[23:0];
  endfunction

  // 12-bit indexes always fall inside the 4096 x 4096 frame
  function void note_pixel(logic [11:0] col, logic [11:0] row, logic [15:0] depth,
                           dpbp_pkg::color_t color);
    point_t      p;
    logic [63:0] zq;
    if (depth == 16'd0) return;
    zq      = ({48'd0, depth} * {40'd0, inv_depth_scale} + 64'd128) >> 8;
    p.x     = axis_coord(col, center_x, zq, inv_focal_x);
    p.y     = axis_coord(row, center_y, zq, inv_focal_y);
    p.z     = (zq > 64'hFFFFFF) ? dpbp_pkg::MAX24U : zq[23:0];
    p.color = color;
    pending_points.insert(pending_points.size(), p);
  endfunction

  function void check_point(point_t got);
    point_t want;
    if (pending_points.size() == 0) begin
      note_failure($sformatf("unexpected point x=%h y=%h z=%h bgr=%h",
                             got.x, got.y, got.z, got.color));
      return;
    end
    want = pending_points.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
        got.color !== want.color)
      note_failure($sformatf("point mismatch: expected x=%h y=%h z=%h bgr=%h, got x=%h y=%h z=%h bgr=%h",
                             want.x, want.y, want.z, want.color,
                             got.x, got.y, got.z, got.color));
  endfunction

  function void close_out();
    if (pending_points.size() != 0)
      note_failure($sformatf("%0d points never came out", pending_points.size()));
  endfunction
endclass

module depth_pixel_back_projection_unit_tb;
  import dpbp_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum int {
    SET_TYPICAL,
    SET_FAR_HIGH,
    SET_RANDOM,
    SET_FAR_LOW,
    SET_FLAT_FOCAL,
    SET_RESET
  } setting_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [11:0]            column_index;
  logic [11:0]            row_index;
  logic [15:0]            depth_value;
  logic [7:0]             blue_value;
  logic [7:0]             green_value;
  logic [7:0]             red_value;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [23:0]            point_x;
  logic [23:0]            point_y;
  logic [23:0]            point_z;
  logic [7:0]             color_blue;
  logic [7:0]             color_green;
  logic [7:0]             color_red;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_len       = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  point_tracker tracker;

  depth_pixel_back_projection_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .column_index (column_index),
    .row_index    (row_index),
    .depth_value  (depth_value),
    .blue_value   (blue_value),
    .green_value  (green_value),
    .red_value    (red_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .color_blue   (color_blue),
    .color_green  (color_green),
    .color_red    (color_red)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // output checked before the input is noted; the pipe is registered from input to output
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_point({point_x, point_y, point_z, color_blue, color_green, color_red});
    if (!rst && in_valid && !in_stall)
      tracker.note_pixel(column_index, row_index, depth_value,
                         {blue_value, green_value, red_value});
  end

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                            input logic [15:0] depth, input logic [7:0] blue,
                            input logic [7:0] green, input logic [7:0] red);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    column_index <= col;
    row_index    <= row;
    depth_value  <= depth;
    blue_value   <= blue;
    green_value  <= green;
    red_value    <= red;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_pixel();
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] depth;
    case ($urandom_range(0, 9))
      0:       col = 12'd0;
      1:       col = 12'hFFF;
      default: col = 12'($urandom_range(0, 4095));
    endcase
    case ($urandom_range(0, 9))
      0:       row = 12'd0;
      1:       row = 12'hFFF;
      default: row = 12'($urandom_range(0, 4095));
    endcase
    case ($urandom_range(0, 9))
      0:       depth = 16'd0;
      1:       depth = 16'hFFFF;
      2:       depth = 16'($urandom_range(1, 15));
      default: depth = 16'($urandom_range(0, 65535));
    endcase
    send_pixel(col, row, depth, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
  endtask

  // sender pauses until every point is out, then lets the pipe run dry
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.pending_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic load_reg(input logic [CFG_INDEX_W-1:0] index, input logic [23:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk) cfg_write <= 1'b0;
    tracker.write_reg(index, data);
  endtask

  task automatic load_all(input logic [23:0] ids, input logic [23:0] cx, input logic [23:0] cy,
                          input logic [23:0] ifx, input logic [23:0] ify);
    load_reg(REG_INV_DEPTH_SCALE, ids);
    load_reg(REG_CENTER_X, cx);
    load_reg(REG_CENTER_Y, cy);
    load_reg(REG_INV_FOCAL_X, ifx);
    load_reg(REG_INV_FOCAL_Y, ify);
  endtask

  task automatic apply_setting(input setting_t kind);
    logic [23:0] ids;
    logic [23:0] ifx;
    logic [23:0] ify;
    case (kind)
      SET_TYPICAL:    load_all(24'd16777, 24'd5120, 24'd3840, 24'd33554, 24'd33554);
      SET_FAR_HIGH:   load_all(24'hFFFFFF, 24'd0, 24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF);
      SET_FAR_LOW:    load_all(24'd1, 24'h00FFFF, 24'd0, 24'd1, 24'd1);
      SET_FLAT_FOCAL: load_all(24'd16777, 24'($urandom_range(0, 65535)),
                               24'($urandom_range(0, 65535)), 24'd0, 24'd0);
      SET_RESET:      load_all(RST_INV_DEPTH_SCALE, {8'd0, RST_CENTER_X}, {8'd0, RST_CENTER_Y},
                               RST_INV_FOCAL_X, RST_INV_FOCAL_Y);
      default: begin
        ids = $urandom_range(0, 1) ? 24'($urandom_range(1, 24'hFFFFFF))
                                   : 24'($urandom_range(1, 24'hFFFF));
        ifx = $urandom_range(0, 1) ? 24'($urandom_range(1, 24'hFFFFFF))
                                   : 24'($urandom_range(1, 24'hFFFF));
        ify = $urandom_range(0, 1) ? 24'($urandom_range(1, 24'hFFFFFF))
                                   : 24'($urandom_range(1, 24'hFFFF));
        // junk above bit 15 of the center writes must be dropped
        load_all(ids, 24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                 ifx, ify);
      end
    endcase
  endtask

  initial begin
    tracker      = new();
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    column_index = '0;
    row_index    = '0;
    depth_value  = '0;
    blue_value   = '0;
    green_value  = '0;
    red_value    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset values, field extremes, zero depth
    send_pixel(12'd0, 12'd0, 16'd1, 8'h00, 8'h00, 8'h00);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd0, 12'hFFF, 16'd0, 8'hAA, 8'h55, 8'h0F);
    send_pixel(12'd2048, 12'd1024, 16'd1000, 8'h55, 8'hAA, 8'hF0);
    send_pixel(12'd325, 12'd253, 16'd4000, 8'h12, 8'h34, 8'h56);
    send_pixel(12'hFFF, 12'd0, 16'd1, 8'h01, 8'h80, 8'h7F);

    // writes to unknown indexes leave everything as it was
    settle();
    load_reg(REG_UNUSED_LO, 24'hFFFFFF);
    load_reg(REG_UNUSED_HI, 24'hFFFFFF);
    send_pixel(12'd100, 12'd3000, 16'd30000, 8'hC3, 8'h3C, 8'h99);
    send_pixel(12'd3000, 12'd100, 16'd7, 8'h66, 8'h11, 8'hEE);

    // saturation of all three coordinates
    settle();
    apply_setting(SET_FAR_HIGH);
    send_pixel(12'hFFF, 12'd0, 16'hFFFF, 8'h10, 8'h20, 8'h30);
    send_pixel(12'd0, 12'hFFF, 16'hFFFF, 8'h40, 8'h50, 8'h60);
    send_pixel(12'd1, 12'd1, 16'd1, 8'h70, 8'h80, 8'h90);
    send_pixel(12'd77, 12'd77, 16'd0, 8'hA0, 8'hB0, 8'hC0);

    // zero focal reciprocals, then zero depth scale
    settle();
    apply_setting(SET_FLAT_FOCAL);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hD0, 8'hE0, 8'hF0);
    send_pixel(12'd0, 12'd0, 16'd12345, 8'h0A, 8'h0B, 8'h0C);
    settle();
    load_reg(REG_INV_DEPTH_SCALE, 24'd0);
    load_reg(REG_INV_FOCAL_X, 24'hFFFFFF);
    send_pixel(12'hFFF, 12'd0, 16'hFFFF, 8'h0D, 8'h0E, 8'h0F);

    // random phases: each idling mode under two settings
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: apply_setting(SET_TYPICAL);
        1: apply_setting(SET_FAR_HIGH);
        3: apply_setting(SET_FAR_LOW);
        5: apply_setting(SET_FLAT_FOCAL);
        7: apply_setting(SET_RESET);
        default: apply_setting(SET_RANDOM);
      endcase
      case (ph / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      repeat (60) send_random_pixel();
    end

    // long receiver hold-off while items keep coming: the pipe fills and stalls
    settle();
    apply_setting(SET_TYPICAL);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 40;
    hold_requests++;
    repeat (40) send_random_pixel();

    @(negedge clk) in_valid <= 1'b0;
    for (int n = 0; n < 5000 && tracker.pending_points.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    tracker.close_out();
    if (tracker.errors == 0)
      $display("depth_pixel_back_projection_unit_tb: clean");
    else
      $display("depth_pixel_back_projection_unit_tb: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("depth_pixel_back_projection_unit_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dpbp_pkg.sv
design/dpbp_axis.sv
design/depth_pixel_back_projection_unit.sv
bench/depth_pixel_back_projection_unit_tb.sv
